/* design/circular_deque_defines.svh */
// Assertion macros used by the deque checker.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled during reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

/* design/cdq_pkg.sv */
// Package with types, codes and constants of the circular deque.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int DATA_W        = 32;

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cdq_cmd;

endpackage

`default_nettype wire

/* design/circular_deque.sv */
// Top level of the circular deque.
`default_nettype none

// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries. Each input beat carries one request (push front, push rear, pop
// front, pop rear) and produces exactly one output beat with the popped word
// (zero unless a pop succeeded), a status code (ok, rejected full, rejected
// empty) and the empty and full flags after the request. After acceptance a
// request passes through the fetch and send states to its output beat, which
// then waits for tready; the next request is taken once that beat has left,
// so the block takes no new request while one is in flight. The fetch state
// loads the result from the entry store's registered read port. The store
// needs no clearing after reset: the block is ready once reset is released.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,  // [31:0] push_value
    input  wire  [1:0]  i_s_axis_tuser,  // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] pop_value
    output logic [3:0]  o_m_axis_tuser   // [1:0] status, [2] now_empty, [3] now_full
);

    t_cdq_cmd              cmd;
    logic signed [DATA_W-1:0] pop_value;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_s_axis_tuser),
        .i_push_value (i_s_axis_tdata),
        .o_pop_value  (pop_value),
        .o_status     (o_m_axis_tuser[1:0]),
        .o_now_empty  (o_m_axis_tuser[2]),
        .o_now_full   (o_m_axis_tuser[3])
    );

    assign o_m_axis_tdata = pop_value;

endmodule

`default_nettype wire

/* design/cdq_ctrl.sv */
// Controller state machine of the circular deque.
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_cdq_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SEND  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid  = (r_state == S_SEND);
    assign o_cmd.accept = (r_state == S_IDLE) && i_rst_n && i_in_valid;
    assign o_cmd.load   = (r_state == S_FETCH);

endmodule

`default_nettype wire

/* design/cdq_dp.sv */
// Datapath of the circular deque: store, indices, empty flag, result register.
`default_nettype none

module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cdq_cmd                i_cmd,
    input  wire  [1:0]              i_req_type,
    input  wire  signed [DATA_W-1:0] i_push_value,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic [1:0]              o_status,
    output logic                    o_now_empty,
    output logic                    o_now_full
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic          r_empty;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic          n_empty;

    logic [1:0]    r_pend_status;
    logic          r_pend_empty;
    logic          r_pend_full;
    logic          r_pop_ok;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] tail_dec;
    logic [AW-1:0] n_tail_inc;
    logic          full;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [1:0]    status;
    logic          pop_ok;

    assign head_inc   = (r_head == LAST) ? '0 : r_head + AW'(1);
    assign head_dec   = (r_head == '0) ? LAST : r_head - AW'(1);
    assign tail_inc   = (r_tail == LAST) ? '0 : r_tail + AW'(1);
    assign tail_dec   = (r_tail == '0) ? LAST : r_tail - AW'(1);
    assign full       = !r_empty && (tail_inc == r_head);
    assign n_tail_inc = (n_tail == LAST) ? '0 : n_tail + AW'(1);
    assign rd_addr    = (i_req_type == REQ_POP_FRONT) ? r_head : r_tail;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_empty = r_empty;
        wr_en   = 1'b0;
        wr_addr = '0;
        status  = ST_OK;
        pop_ok  = 1'b0;
        case (i_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (full) begin
                    status = ST_FULL;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                end else if (i_req_type == REQ_PUSH_FRONT) begin
                    n_head  = head_dec;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                end else begin
                    n_tail  = tail_inc;
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_empty) begin
                    status = ST_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    if (r_head == r_tail) begin
                        n_empty = 1'b1;
                        n_head  = '0;
                        n_tail  = '0;
                    end else if (i_req_type == REQ_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        n_tail = tail_dec;
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= i_push_value;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= status;
            r_pend_empty  <= n_empty;
            r_pend_full   <= !n_empty && (n_tail_inc == n_head);
            r_pop_ok      <= pop_ok;
        end
        if (i_cmd.load) begin
            o_pop_value <= r_pop_ok ? r_rd_data : '0;
            o_status    <= r_pend_status;
            o_now_empty <= r_pend_empty;
            o_now_full  <= r_pend_full;
        end
    end

endmodule

`default_nettype wire

/* design/cdq_checker.sv */
// Port-level checker for the circular deque and its bind.
`default_nettype none

`include "circular_deque_defines.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        i_s_tready,
    input wire        i_m_tvalid,
    input wire [31:0] i_m_tdata,
    input wire [3:0]  i_m_tuser
);

    `CDQ_ASSERT_NOW(a_not_both, i_clk, i_rst_n, i_m_tvalid, !(i_m_tuser[2] && i_m_tuser[3]))
    `CDQ_ASSERT_NOW(a_full_rej, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser[1:0] == ST_FULL),
        i_m_tuser[3])
    `CDQ_ASSERT_NOW(a_empty_rej, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser[1:0] == ST_EMPTY),
        i_m_tuser[2] && (i_m_tdata == 32'd0))
    `CDQ_ASSERT_NOW(a_one_busy, i_clk, i_rst_n, i_m_tvalid, !i_s_tready)
    `CDQ_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire

/* tb/circular_deque_tb.sv */
// Testbench for the circular deque: random and directed requests checked against a deque mirror.
`default_nettype none

module circular_deque_tb;
    import cdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int CLK_PERIOD  = 12;
    localparam int LIMIT_TICKS = 300000 * CLK_PERIOD;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
        logic        now_empty;
        logic        now_full;
    } deque_reply_t;

    class deque_mirror;
        logic [31:0]  words [DEPTH];
        int           head;
        int           tail;
        bit           empty;
        deque_reply_t pending_replies[$];
        int           mismatch_count;

        function new();
            head           = 0;
            tail           = 0;
            empty          = 1'b1;
            mismatch_count = 0;
        endfunction

        function bit is_full();
            return !empty && ((tail + 1) % DEPTH) == head;
        endfunction

        function void apply_request(logic [1:0] req, logic [31:0] value);
            deque_reply_t reply;
            int           at;
            reply = '0;
            reply.status = ST_OK;
            if (req == REQ_PUSH_FRONT || req == REQ_PUSH_REAR) begin
                if (is_full()) begin
                    reply.status = ST_FULL;
                end else if (empty) begin
                    head     = 0;
                    tail     = 0;
                    empty    = 1'b0;
                    words[0] = value;
                end else if (req == REQ_PUSH_FRONT) begin
                    head        = (head + DEPTH - 1) % DEPTH;
                    words[head] = value;
                end else begin
                    tail        = (tail + 1) % DEPTH;
                    words[tail] = value;
                end
            end else begin
                if (empty) begin
                    reply.status = ST_EMPTY;
                end else begin
                    at = (req == REQ_POP_FRONT) ? head : tail;
                    reply.pop_value = words[at];
                    if (head == tail) begin
                        empty = 1'b1;
                        head  = 0;
                        tail  = 0;
                    end else if (req == REQ_POP_FRONT) begin
                        head = (head + 1) % DEPTH;
                    end else begin
                        tail = (tail + DEPTH - 1) % DEPTH;
                    end
                end
            end
            reply.now_empty = empty;
            reply.now_full  = is_full();
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [31:0] data, logic [3:0] user);
            deque_reply_t want;
            if (pending_replies.size() == 0) begin
                $error("unexpected beat: pop_value=%0d tuser=%h", $signed(data), user);
                mismatch_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (data !== want.pop_value) begin
                $error("pop_value: expected %0d, got %0d",
                       $signed(want.pop_value), $signed(data));
                mismatch_count++;
            end
            if (user[1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, user[1:0]);
                mismatch_count++;
            end
            if (user[2] !== want.now_empty) begin
                $error("now_empty: expected %0d, got %0d", want.now_empty, user[2]);
                mismatch_count++;
            end
            if (user[3] !== want.now_full) begin
                $error("now_full: expected %0d, got %0d", want.now_full, user[3]);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] push_value
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] pop_value
    logic [3:0]  m_tuser;   // [1:0] status, [2] now_empty, [3] now_full

    deque_mirror mirror;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_request;
    int          hold_left;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TICKS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            mirror.check_reply(m_tdata, m_tuser);
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= req;
        do @(posedge i_clk); while (!s_tready);
        mirror.apply_request(req, value);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int count);
        int          left;
        int          push_pct;
        int          seg_kind;
        logic [1:0]  req;
        left     = 0;
        seg_kind = 0;
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (left == 0) begin
                case (seg_kind)
                    0: begin
                        push_pct = 90;
                        left     = $urandom_range(150, 200);
                    end
                    1: begin
                        push_pct = 10;
                        left     = $urandom_range(150, 200);
                    end
                    default: begin
                        push_pct = 50;
                        left     = $urandom_range(20, 60);
                    end
                endcase
                seg_kind = (seg_kind + 1) % 3;
            end
            left--;
            if ($urandom_range(99) < push_pct) begin
                req = $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
            end else begin
                req = $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
            end
            send_request(req, pick_word());
        end
    endtask

    initial begin
        mirror         = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_PUSH_FRONT;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(REQ_POP_FRONT,  32'h1357_9BDF);
        send_request(REQ_POP_REAR,   32'hFFFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_REAR,  32'h8000_0000);
        send_request(REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(REQ_PUSH_REAR,  32'hFFFF_FFFF);
        send_request(REQ_POP_REAR,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'hFFFF_FFFF);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_REAR,   32'h0000_0000);
        send_request(REQ_POP_REAR,   32'h0000_0000);
        send_request(REQ_PUSH_REAR,  32'hA5A5_A5A5);
        send_request(REQ_POP_FRONT,  32'h5A5A_5A5A);
        send_request(REQ_PUSH_FRONT, 32'h1234_5678);
        send_request(REQ_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(REQ_PUSH_REAR,  32'h0000_0001);
        send_request(REQ_POP_REAR,   32'hFFFF_FFFF);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);

        hold_request = 1'b1;
        send_random(240);

        send_idle_pct  = 76;
        recv_stall_pct = 0;
        send_random(230);

        send_idle_pct  = 0;
        recv_stall_pct = 76;
        send_random(230);

        send_idle_pct  = 7;
        recv_stall_pct = 7;
        send_random(240);

        s_tvalid <= 1'b0;
        while (mirror.pending_replies.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mirror.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
